// ===== hdl/crg_pkg.sv =====
package crg_pkg;

	localparam int COLOR_BITS = 16;
	localparam int NUM_OCT = 8;
	localparam int OCT_IDX_BITS = 3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// midpoint decision increments: east move and south-east move
	localparam int DEC_STEP_E = 3;
	localparam int DEC_STEP_SE = 5;

	// octant mirror table, one bit per octant: swap the offsets, negate column, negate row
	localparam logic [NUM_OCT-1:0] OCT_SWAP = 8'b0011_1100;
	localparam logic [NUM_OCT-1:0] OCT_NEG_X = 8'b1111_0000;
	localparam logic [NUM_OCT-1:0] OCT_NEG_Y = 8'b1010_1010;

	typedef struct packed {
		logic multi;
		logic pix_valid;
		logic done;
	} burst_ctl_t;

endpackage

// ===== hdl/crg_burst_out.sv =====
module crg_burst_out #(
	parameter int COORD_BITS = 16,
	parameter int RADIUS_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  crg_pkg::burst_ctl_t       ctl,
	input  logic [COORD_BITS-1:0]     base_x,
	input  logic [COORD_BITS-1:0]     base_y,
	input  logic [RADIUS_BITS-1:0]    off_a,
	input  logic [RADIUS_BITS-1:0]    off_b,
	input  logic [crg_pkg::COLOR_BITS-1:0] color,
	output logic                      load_ok,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COORD_BITS-1:0]     pixel_x,
	output logic [COORD_BITS-1:0]     pixel_y,
	output logic [crg_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                      pixel_valid,
	output logic                      last_of_step,
	output logic                      circle_done
);
	import crg_pkg::*;

	logic                    valid_s2;
	burst_ctl_t              ctl_s2;
	logic [COORD_BITS-1:0]   base_x_s2;
	logic [COORD_BITS-1:0]   base_y_s2;
	logic [RADIUS_BITS-1:0]  off_a_s2;
	logic [RADIUS_BITS-1:0]  off_b_s2;
	logic [COLOR_BITS-1:0]   color_s2;
	logic [OCT_IDX_BITS-1:0] idx_q;

	logic                    take;
	logic                    last;
	logic [COORD_BITS-1:0]   dx;
	logic [COORD_BITS-1:0]   dy;
	logic [COORD_BITS-1:0]   px;
	logic [COORD_BITS-1:0]   py;

	assign last = !ctl_s2.multi || (idx_q == OCT_IDX_BITS'(NUM_OCT - 1));
	assign take = valid_s2 && !out_stall;
	assign load_ok = !valid_s2 || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + OCT_IDX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s2 <= ctl;
			base_x_s2 <= base_x;
			base_y_s2 <= base_y;
			off_a_s2 <= off_a;
			off_b_s2 <= off_b;
			color_s2 <= color;
		end
	end

	// mirror the octant offsets onto the center
	always_comb begin
		if (OCT_SWAP[idx_q]) begin
			dx = COORD_BITS'(off_b_s2);
			dy = COORD_BITS'(off_a_s2);
		end else begin
			dx = COORD_BITS'(off_a_s2);
			dy = COORD_BITS'(off_b_s2);
		end
		px = OCT_NEG_X[idx_q] ? base_x_s2 - dx : base_x_s2 + dx;
		py = OCT_NEG_Y[idx_q] ? base_y_s2 - dy : base_y_s2 + dy;
	end

	assign out_valid = valid_s2;
	assign pixel_valid = ctl_s2.pix_valid;
	assign pixel_x = ctl_s2.pix_valid ? px : '0;
	assign pixel_y = ctl_s2.pix_valid ? py : '0;
	assign pixel_color = ctl_s2.pix_valid ? color_s2 : '0;
	assign last_of_step = last;
	assign circle_done = ctl_s2.done;

endmodule

// ===== hdl/circle_raster_generator_unit.sv =====
// Channel | handshake           | payload
// input   | in_valid / in_stall  | operation, origin_x, origin_y, radius, draw_color, fill_mode
// output  | out_valid / out_stall| pixel_x, pixel_y, pixel_color, pixel_valid, last_of_step, circle_done
//
// One word enters per cycle into the input register while in_stall is low; its step runs
// from that register and writes a result burst register. A start word yields no output word.
// A fill step or an idle step yields one output word; an outline step that plots pixels
// yields eight, one per cycle unless out_stall holds them; the octant serializer sets outline throughput.
// Reset clears the circle state and both valid flags; no memory needs clearing.
// A stall on the output holds the burst; the input stalls once the burst register
// cannot take the waiting step.
module circle_raster_generator_unit #(
	parameter int COORD_BITS = 16,
	parameter int RADIUS_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [COORD_BITS-1:0]     origin_x,
	input  logic [COORD_BITS-1:0]     origin_y,
	input  logic [RADIUS_BITS-1:0]    radius,
	input  logic [crg_pkg::COLOR_BITS-1:0] draw_color,
	input  logic                      fill_mode,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COORD_BITS-1:0]     pixel_x,
	output logic [COORD_BITS-1:0]     pixel_y,
	output logic [crg_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                      pixel_valid,
	output logic                      last_of_step,
	output logic                      circle_done
);
	import crg_pkg::*;

	localparam int DEC_BITS = RADIUS_BITS + 4;
	localparam int SPAN_BITS = RADIUS_BITS + 1;
	localparam int SQ_BITS = 2 * RADIUS_BITS;

	logic                   valid_s1;
	logic                   op_s1;
	logic [COORD_BITS-1:0]  cx_s1;
	logic [COORD_BITS-1:0]  cy_s1;
	logic [RADIUS_BITS-1:0] rad_s1;
	logic [COLOR_BITS-1:0]  color_s1;
	logic                   fill_s1;

	logic                        active_q;
	logic                        mode_fill_q;
	logic [COORD_BITS-1:0]       ctr_x_q;
	logic [COORD_BITS-1:0]       ctr_y_q;
	logic [RADIUS_BITS-1:0]      rad_q;
	logic [SQ_BITS-1:0]          rad_sq_q;
	logic [COLOR_BITS-1:0]       color_q;
	logic [RADIUS_BITS-1:0]      oct_x_q;
	logic [RADIUS_BITS-1:0]      oct_y_q;
	logic signed [DEC_BITS-1:0]  decision_q;
	logic [SPAN_BITS-1:0]        scan_row_q;
	logic [SPAN_BITS-1:0]        scan_col_q;

	logic                        active_n;
	logic [RADIUS_BITS-1:0]      oct_x_n;
	logic [RADIUS_BITS-1:0]      oct_y_n;
	logic signed [DEC_BITS-1:0]  decision_n;
	logic [SPAN_BITS-1:0]        scan_row_n;
	logic [SPAN_BITS-1:0]        scan_col_n;

	logic                        load_ok;
	logic                        s1_fire;
	logic                        burst_load;
	burst_ctl_t                  b_ctl;
	logic [COORD_BITS-1:0]       b_x;
	logic [COORD_BITS-1:0]       b_y;
	logic [RADIUS_BITS-1:0]      b_a;
	logic [RADIUS_BITS-1:0]      b_b;

	logic signed [DEC_BITS-1:0]  x_ext;
	logic signed [DEC_BITS-1:0]  y_ext;
	logic [SPAN_BITS-1:0]        span;
	logic [SPAN_BITS-1:0]        rad_ext;
	logic [SPAN_BITS-1:0]        col_inc;
	logic [RADIUS_BITS-1:0]      dist_x;
	logic [RADIUS_BITS-1:0]      dist_y;
	logic [SQ_BITS:0]            dist_sq;

	assign s1_fire = valid_s1 && ((op_s1 == OP_START) || load_ok);
	assign burst_load = s1_fire && (op_s1 == OP_STEP);
	assign in_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			cx_s1 <= origin_x;
			cy_s1 <= origin_y;
			rad_s1 <= radius;
			color_s1 <= draw_color;
			fill_s1 <= fill_mode;
		end
	end

	assign x_ext = $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, oct_x_q});
	assign y_ext = $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, oct_y_q});
	assign span = {rad_q, 1'b0};
	assign rad_ext = {1'b0, rad_q};
	assign col_inc = scan_col_q + SPAN_BITS'(1);
	assign dist_x = RADIUS_BITS'((scan_col_q >= rad_ext) ? scan_col_q - rad_ext
		: rad_ext - scan_col_q);
	assign dist_y = RADIUS_BITS'((scan_row_q >= rad_ext) ? scan_row_q - rad_ext
		: rad_ext - scan_row_q);
	assign dist_sq = (SQ_BITS+1)'(dist_x * dist_x) + (SQ_BITS+1)'(dist_y * dist_y);

	always_comb begin
		active_n = active_q;
		oct_x_n = oct_x_q;
		oct_y_n = oct_y_q;
		decision_n = decision_q;
		scan_row_n = scan_row_q;
		scan_col_n = scan_col_q;
		b_ctl = '{multi: 1'b0, pix_valid: 1'b0, done: 1'b1};
		b_x = ctr_x_q;
		b_y = ctr_y_q;
		b_a = oct_x_q;
		b_b = oct_y_q;
		if (!active_q) begin
			b_ctl = '{multi: 1'b0, pix_valid: 1'b0, done: 1'b1};
		end else if (!mode_fill_q) begin
			if (oct_x_q < oct_y_q) begin
				if (decision_q < 0) begin
					decision_n = decision_q + (x_ext <<< 1) + DEC_BITS'(DEC_STEP_E);
				end else begin
					decision_n = decision_q + ((x_ext - y_ext) <<< 1)
						+ DEC_BITS'(DEC_STEP_SE);
					oct_y_n = oct_y_q - RADIUS_BITS'(1);
				end
				oct_x_n = oct_x_q + RADIUS_BITS'(1);
				b_ctl = '{multi: 1'b1, pix_valid: 1'b1, done: !(oct_x_n < oct_y_n)};
				active_n = oct_x_n < oct_y_n;
			end else begin
				active_n = 1'b0;
			end
		end else begin
			if (scan_row_q < span && scan_col_q < span) begin
				if (col_inc >= span) begin
					scan_col_n = '0;
					scan_row_n = scan_row_q + SPAN_BITS'(1);
				end else begin
					scan_col_n = col_inc;
				end
				b_x = ctr_x_q - COORD_BITS'(rad_q) + COORD_BITS'(scan_col_q);
				b_y = ctr_y_q - COORD_BITS'(rad_q) + COORD_BITS'(scan_row_q);
				b_a = '0;
				b_b = '0;
				b_ctl = '{multi: 1'b0, pix_valid: (dist_sq <= (SQ_BITS+1)'(rad_sq_q)),
					done: scan_row_n >= span};
				active_n = !(scan_row_n >= span);
			end else begin
				active_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_fill_q <= 1'b0;
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			rad_q <= '0;
			rad_sq_q <= '0;
			color_q <= '0;
			oct_x_q <= '0;
			oct_y_q <= '0;
			decision_q <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
		end else if (s1_fire) begin
			if (op_s1 == OP_START) begin
				active_q <= 1'b1;
				mode_fill_q <= fill_s1;
				ctr_x_q <= cx_s1;
				ctr_y_q <= cy_s1;
				rad_q <= rad_s1;
				rad_sq_q <= SQ_BITS'(rad_s1 * rad_s1);
				color_q <= color_s1;
				oct_x_q <= '0;
				oct_y_q <= rad_s1;
				decision_q <= DEC_BITS'(1) - $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, rad_s1});
				scan_row_q <= '0;
				scan_col_q <= '0;
			end else begin
				active_q <= active_n;
				oct_x_q <= oct_x_n;
				oct_y_q <= oct_y_n;
				decision_q <= decision_n;
				scan_row_q <= scan_row_n;
				scan_col_q <= scan_col_n;
			end
		end
	end

	crg_burst_out #(
		.COORD_BITS(COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_burst_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(burst_load),
		.ctl(b_ctl),
		.base_x(b_x),
		.base_y(b_y),
		.off_a(b_a),
		.off_b(b_b),
		.color(color_q),
		.load_ok(load_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.pixel_valid(pixel_valid),
		.last_of_step(last_of_step),
		.circle_done(circle_done)
	);

	a_nonpix_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> last_of_step)
		else $error("non-pixel word not single");

	a_nonpix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && pixel_color == '0)
		else $error("non-pixel word carries data");

	a_octant_order: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !mode_fill_q |-> oct_x_q <= oct_y_q)
		else $error("outline octant crossed while active");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && mode_fill_q && rad_q != '0 |-> scan_row_q < span && scan_col_q < span)
		else $error("fill scan out of box while active");

endmodule

// ===== verif/tb_circle_raster_generator_unit.sv =====
module tb_circle_raster_generator_unit;
	import crg_pkg::*;

	localparam int COORD_W = 16;
	localparam int RAD_W = 10;
	localparam int ITEM_TOTAL = 160;
	localparam int QUIET_LO = 40;
	localparam int QUIET_HI = 80;
	localparam int HOLD_AT = 110;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_AT = 90;
	localparam int SETTLE_CYCLES = 20;
	localparam int TIMEOUT = 2_000_000;

	localparam logic [7:0] MIR_SWAP = 8'b0011_1100;
	localparam logic [7:0] MIR_NEG_X = 8'b1111_0000;
	localparam logic [7:0] MIR_NEG_Y = 8'b1010_1010;

	typedef struct packed {
		logic                 op;
		logic [COORD_W-1:0]   cx;
		logic [COORD_W-1:0]   cy;
		logic [RAD_W-1:0]     rad;
		logic [COLOR_BITS-1:0] color;
		logic                 fill;
		logic                 wait_idle;
	} draw_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COLOR_BITS-1:0] color;
		logic                 valid;
		logic                 last;
		logic                 done;
	} pixel_word_t;

	localparam pixel_word_t NO_PIXEL = '{x: '0, y: '0, color: '0, valid: 1'b0,
		last: 1'b1, done: 1'b1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = 1'b0;
	logic [COORD_W-1:0]    origin_x = '0;
	logic [COORD_W-1:0]    origin_y = '0;
	logic [RAD_W-1:0]      radius = '0;
	logic [COLOR_BITS-1:0] draw_color = '0;
	logic                  fill_mode = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_W-1:0]    pixel_x;
	logic [COORD_W-1:0]    pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  pixel_valid;
	logic                  last_of_step;
	logic                  circle_done;

	draw_item_t  pending_items[$];
	pixel_word_t pixel_q[$];
	draw_item_t  cur_item;
	int          accepted_cnt = 0;
	int          item_total = 0;
	int          err_cnt = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        drain_done = 1'b0;
	logic        skip;

	// circle state mirrored by the predictor
	logic                  circ_on = 1'b0;
	logic                  circ_fill = 1'b0;
	logic [COORD_W-1:0]    ctr_col = '0;
	logic [COORD_W-1:0]    ctr_row = '0;
	logic [RAD_W-1:0]      circ_rad = '0;
	logic [COLOR_BITS-1:0] circ_color = '0;
	logic [RAD_W-1:0]      oct_a = '0;
	logic [RAD_W-1:0]      oct_b = '0;
	int                    midpoint_err = 0;
	logic [RAD_W:0]        scan_r = '0;
	logic [RAD_W:0]        scan_c = '0;

	circle_raster_generator_unit i_dut (.*);

	always #5 clk = ~clk;

	task automatic predict_pixels(input draw_item_t it);
		logic [COORD_W-1:0] xs[8];
		logic [COORD_W-1:0] ys[8];
		logic [RAD_W-1:0]   a;
		logic [RAD_W-1:0]   b;
		pixel_word_t        w;
		int                 span;
		int                 dx;
		int                 dy;
		logic               fin;
		if (it.op == OP_START) begin
			ctr_col = it.cx;
			ctr_row = it.cy;
			circ_rad = it.rad;
			circ_color = it.color;
			circ_fill = it.fill;
			oct_a = '0;
			oct_b = it.rad;
			midpoint_err = 1 - int'(it.rad);
			scan_r = '0;
			scan_c = '0;
			circ_on = 1'b1;
			return;
		end
		if (!circ_on) begin
			pixel_q.push_back(NO_PIXEL);
			return;
		end
		if (circ_fill) begin
			span = 2 * int'(circ_rad);
			if (int'(scan_r) >= span || int'(scan_c) >= span) begin
				circ_on = 1'b0;
				pixel_q.push_back(NO_PIXEL);
				return;
			end
			dx = int'(scan_c) - int'(circ_rad);
			if (dx < 0)
				dx = -dx;
			dy = int'(scan_r) - int'(circ_rad);
			if (dy < 0)
				dy = -dy;
			w.valid = (dx * dx + dy * dy) <= int'(circ_rad) * int'(circ_rad);
			w.x = w.valid ? ctr_col - COORD_W'(circ_rad) + COORD_W'(scan_c) : '0;
			w.y = w.valid ? ctr_row - COORD_W'(circ_rad) + COORD_W'(scan_r) : '0;
			w.color = w.valid ? circ_color : '0;
			scan_c = scan_c + (RAD_W+1)'(1);
			if (int'(scan_c) >= span) begin
				scan_c = '0;
				scan_r = scan_r + (RAD_W+1)'(1);
			end
			w.done = int'(scan_r) >= span;
			w.last = 1'b1;
			if (w.done)
				circ_on = 1'b0;
			pixel_q.push_back(w);
			return;
		end
		if (!(oct_a < oct_b)) begin
			circ_on = 1'b0;
			pixel_q.push_back(NO_PIXEL);
			return;
		end
		for (int k = 0; k < 8; k++) begin
			a = MIR_SWAP[k] ? oct_b : oct_a;
			b = MIR_SWAP[k] ? oct_a : oct_b;
			xs[k] = MIR_NEG_X[k] ? ctr_col - COORD_W'(a) : ctr_col + COORD_W'(a);
			ys[k] = MIR_NEG_Y[k] ? ctr_row - COORD_W'(b) : ctr_row + COORD_W'(b);
		end
		if (midpoint_err < 0) begin
			midpoint_err = midpoint_err + 2 * int'(oct_a) + 3;
		end else begin
			midpoint_err = midpoint_err + 2 * (int'(oct_a) - int'(oct_b)) + 5;
			oct_b = oct_b - RAD_W'(1);
		end
		oct_a = oct_a + RAD_W'(1);
		fin = !(oct_a < oct_b);
		if (fin)
			circ_on = 1'b0;
		for (int k = 0; k < 8; k++) begin
			w = '{x: xs[k], y: ys[k], color: circ_color, valid: 1'b1,
				last: (k == 7), done: fin};
			pixel_q.push_back(w);
		end
	endtask

	task automatic queue_start(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
		input logic [RAD_W-1:0] r, input logic [COLOR_BITS-1:0] color, input logic fill);
		draw_item_t it;
		it = '{op: OP_START, cx: cx, cy: cy, rad: r, color: color, fill: fill,
			wait_idle: 1'b0};
		if (!drain_done && pending_items.size() >= DRAIN_AT) begin
			it.wait_idle = 1'b1;
			drain_done = 1'b1;
		end
		pending_items.push_back(it);
	endtask

	task automatic queue_steps(input int n);
		draw_item_t it;
		for (int i = 0; i < n; i++) begin
			it = '{op: OP_STEP, cx: COORD_W'($urandom), cy: COORD_W'($urandom),
				rad: RAD_W'($urandom), color: COLOR_BITS'($urandom),
				fill: 1'($urandom_range(0, 1)), wait_idle: 1'b0};
			pending_items.push_back(it);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			accepted_cnt <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_pixels(cur_item);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				skip = !(accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI) &&
					($urandom_range(0, 99) < 10);
				if (pending_items.size() != 0 && !skip &&
					!(pending_items[0].wait_idle && pixel_q.size() != 0)) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					operation <= cur_item.op;
					origin_x <= cur_item.cx;
					origin_y <= cur_item.cy;
					radius <= cur_item.rad;
					draw_color <= cur_item.color;
					fill_mode <= cur_item.fill;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left != 1);
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected word: x %0h y %0h valid %0b", pixel_x, pixel_y,
					pixel_valid);
				err_cnt++;
			end else begin
				want = pixel_q.pop_front();
				check_field("pixel_x", 32'(want.x), 32'(pixel_x));
				check_field("pixel_y", 32'(want.y), 32'(pixel_y));
				check_field("pixel_color", 32'(want.color), 32'(pixel_color));
				check_field("pixel_valid", 32'(want.valid), 32'(pixel_valid));
				check_field("last_of_step", 32'(want.last), 32'(last_of_step));
				check_field("circle_done", 32'(want.done), 32'(circle_done));
			end
		end
	end

	initial begin
		int          pick;
		int          n;
		logic        fill;
		logic [RAD_W-1:0] r;

		queue_steps(1);
		queue_start(COORD_W'($urandom), COORD_W'($urandom), '0, COLOR_BITS'($urandom), 1'b0);
		queue_steps(2);
		queue_start(COORD_W'($urandom), COORD_W'($urandom), '0, COLOR_BITS'($urandom), 1'b1);
		queue_steps(1);
		queue_start(16'hFFFF, 16'h0000, 10'd1, 16'hFFFF, 1'b0);
		queue_steps(2);
		queue_start(16'h0000, 16'hFFFF, 10'd1, 16'h0000, 1'b1);
		queue_steps(4);
		queue_start(16'h8000, 16'h7FFF, 10'h3FF, 16'hA5A5, 1'b0);
		queue_steps(2);
		queue_start(16'h0001, 16'hFFFE, 10'd2, 16'h5A5A, 1'b1);
		queue_steps(2);
		queue_start(COORD_W'($urandom), COORD_W'($urandom), 10'd3, COLOR_BITS'($urandom),
			1'b0);
		queue_steps(2);

		while (pending_items.size() < ITEM_TOTAL) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				if ($urandom_range(0, 1))
					queue_steps(1);
				else
					queue_start(COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom),
						COLOR_BITS'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				fill = 1'($urandom_range(0, 1));
				if (fill) begin
					r = RAD_W'($urandom_range(0, 3));
					n = 4 * int'(r) * int'(r) + 1;
				end else if ($urandom_range(0, 7) == 0) begin
					r = RAD_W'($urandom_range(0, 1023));
					n = $urandom_range(1, 6);
				end else begin
					r = RAD_W'($urandom_range(0, 12));
					n = int'(r) + 1;
				end
				if ($urandom_range(0, 4) == 0)
					n = $urandom_range(0, n);
				queue_start(COORD_W'($urandom), COORD_W'($urandom), r, COLOR_BITS'($urandom),
					fill);
				queue_steps(n);
			end
		end
		item_total = pending_items.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_cnt < item_total || pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
